>>> hw/rtl/bitmap_block_allocator_unit_defines.svh
// assertion helpers for the bitmap allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int OP_W     = 1;
    localparam int FIELD_W  = 12;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 13;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic rd;
        logic upd;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

>>> hw/rtl/bba_if.sv
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] free_index;

    modport source (output valid, output op, output free_index, input ready);
    modport sink   (input valid, input op, input free_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink   (input valid, input status, input granted_index, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bitmap_block_allocator_unit.sv
// channel   dir  handshake       payload
// i_req     in   valid / ready   op, free_index
// o_rsp     out  valid / ready   status, granted_index
// i_cfg     in   i_cfg_we        i_cfg_wdata (pool limit)
//
// one request at a time; allocate reads the bitmap words, one per cycle, until it
// finds one with a free bit or reaches the last of the MAP_WORDS words
// free walks the words the same way up to the one that holds the index
// sync active-low reset clears the per-word valid bits, so the map reads free
// a finished result waits in the output register while the next request is taken

`default_nettype none
`include "bitmap_block_allocator_unit_defines.svh"

module bitmap_block_allocator_unit import bba_pkg::*; #(
    parameter int MAP_ENTRIES = 4096,
    parameter int WORD_BITS   = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bba_req_if.sink            i_req,
    bba_rsp_if.source          o_rsp,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bba_datapath #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_op            (i_req.op),
        .i_free_index    (i_req.free_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_granted_index (o_rsp.granted_index)
    );

    assign i_req.ready = w_in_ready;

    `BBA_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.fin, !(o_rsp.valid && !o_rsp.ready), "result overwritten before taken")
    `BBA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request taken while busy")
    `BBA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_rsp.valid, o_rsp.status == ST_DONE || o_rsp.status == ST_FULL || o_rsp.status == ST_RANGE, "bad status code")
    `BBA_ASSERT_NOW(a_grant_zero_on_fail, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != ST_DONE, o_rsp.granted_index == '0, "nonzero index on failure")

endmodule

`default_nettype wire

>>> hw/rtl/bba_ctrl.sv
`default_nettype none

module bba_ctrl import bba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_UPD,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.last) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/bba_datapath.sv
`default_nettype none

module bba_datapath import bba_pkg::*; #(
    parameter int MAP_ENTRIES = 4096,
    parameter int WORD_BITS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [OP_W-1:0]     i_op,
    input  logic [FIELD_W-1:0]  i_free_index,
    input  logic                i_cfg_we,
    input  logic [LIMIT_W-1:0]  i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [FIELD_W-1:0]  o_granted_index
);

    localparam int MAP_WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int TOTAL     = MAP_WORDS * WORD_BITS;
    localparam int TW        = $clog2(TOTAL + 1);
    localparam int CW        = (TW > LIMIT_W) ? TW : LIMIT_W;

    localparam logic [CW-1:0]      C_TOTAL   = CW'(TOTAL);
    localparam logic [CW-1:0]      C_ENTRIES = CW'(MAP_ENTRIES);
    localparam logic [CW-1:0]      C_WBITS   = CW'(WORD_BITS);
    localparam logic [WADDR_W-1:0] C_LAST    = WADDR_W'(MAP_WORDS - 1);
    localparam logic [CW-1:0]      C_LIM_RST =
        (CW'(LIMIT_RESET) < C_ENTRIES) ? CW'(LIMIT_RESET) : C_ENTRIES;

    function automatic logic [BIT_W-1:0] f_first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_wvld;
    logic [CW-1:0]        r_lim;

    logic [OP_W-1:0]      r_op;
    logic [FIELD_W-1:0]   r_fidx;
    logic [WADDR_W-1:0]   r_addr;
    logic [WADDR_W-1:0]   r_data_addr;
    logic [CW-1:0]        r_next_base;
    logic [CW-1:0]        r_base;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [BIT_W-1:0]     r_bit;
    logic [CW-1:0]        r_idx;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [FIELD_W-1:0]   r_granted;

    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_new_word;
    logic [BIT_W-1:0]     w_enc;
    logic [CW-1:0]        w_fx;
    logic [CW-1:0]        w_fx_off;
    logic [CW-1:0]        w_cfg_ext;
    logic                 w_alloc;
    logic                 w_alloc_hit;
    logic                 w_free_hit;
    logic                 w_in_lim;

    assign w_alloc     = (r_op == OP_ALLOC);
    assign w_word      = r_rd_vld ? r_rd_data : '0;
    assign w_enc       = f_first_zero(w_word);
    assign w_alloc_hit = ~(&w_word);
    assign w_fx        = CW'(r_fidx);
    assign w_fx_off    = w_fx - r_base;
    assign w_free_hit  = (w_fx >= r_base) && (w_fx < r_base + C_WBITS);
    assign w_in_lim    = (r_idx < r_lim);
    assign w_mask      = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit;
    assign w_new_word  = w_alloc ? (w_word | w_mask) : (w_word & ~w_mask);
    assign w_cfg_ext   = CW'(i_cfg_wdata);

    assign o_stat.hit      = w_alloc ? w_alloc_hit : w_free_hit;
    assign o_stat.last     = (r_data_addr == C_LAST);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    // bitmap words, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_addr];
        end
        if (i_cmd.fin && w_in_lim) begin
            r_mem[r_data_addr] <= w_new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld      <= '0;
            r_lim       <= C_LIM_RST;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lim <= (w_cfg_ext < C_ENTRIES) ? w_cfg_ext : C_ENTRIES;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= r_wvld[r_addr];
            end
            if (i_cmd.fin && w_in_lim) begin
                r_wvld[r_data_addr] <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_fidx      <= i_free_index;
            r_addr      <= '0;
            r_next_base <= '0;
        end
        if (i_cmd.rd) begin
            r_data_addr <= r_addr;
            r_base      <= r_next_base;
            r_addr      <= r_addr + WADDR_W'(1);
            r_next_base <= r_next_base + C_WBITS;
        end
        if (i_cmd.upd) begin
            if (w_alloc) begin
                r_bit <= w_enc;
                r_idx <= w_alloc_hit ? (r_base + CW'(w_enc)) : C_TOTAL;
            end else begin
                r_bit <= w_fx_off[BIT_W-1:0];
                r_idx <= w_fx;
            end
        end
        if (i_cmd.fin) begin
            if (w_in_lim) begin
                r_status  <= ST_DONE;
                r_granted <= w_alloc ? r_idx[FIELD_W-1:0] : '0;
            end else begin
                r_status  <= w_alloc ? ST_FULL : ST_RANGE;
                r_granted <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;

endmodule

`default_nettype wire
